### design/csps_pkg.sv
// shared types, constants and codes of the cd stream playback supervisor
`timescale 1ns / 1ps
`default_nettype none

package csps_pkg;

    // field widths
    localparam int SECT_W   = 19;
    localparam int END_W    = 20;
    localparam int VOL_W    = 8;
    localparam int CHAN_W   = 5;
    localparam int MS_W     = 23;
    localparam int RESYNC_W = 6;
    localparam int POS_W    = 21;

    localparam logic [SECT_W-1:0]   SECT_MAX     = '1;
    localparam logic [RESYNC_W-1:0] RESYNC_TICKS = 6'd60;

    // sectors per minute and per second of the msf position
    localparam logic [POS_W-1:0] MIN_SECTORS = 21'd4500;
    localparam logic [POS_W-1:0] SEC_SECTORS = 21'd75;

    // elapsed ms = elapsed * 1000 / 75 = elapsed * 40 / 3, done as
    // elapsed * (40 * ceil(2^27 / 3)) >> 27, exact for every 19-bit elapsed
    localparam int                    MS_MULT_W = 31;
    localparam logic [MS_MULT_W-1:0]  MS_MULT   = 31'd1789569720;
    localparam int                    MS_SHIFT  = 27;
    localparam int                    PROD_W    = SECT_W + MS_MULT_W;

    // result slots per item
    localparam int SLOTS  = 3;
    localparam int SLOT_W = 2;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_PLAY  = 2'd1,
        CMD_PAUSE = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_PLAY    = 3'd1,
        ACT_SEEK    = 3'd2,
        ACT_PAUSE   = 3'd3,
        ACT_REINIT  = 3'd4,
        ACT_FILTVOL = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        REG_START  = 3'd0,
        REG_LENGTH = 3'd1,
        REG_LOOP   = 3'd2,
        REG_CHAN   = 3'd3,
        REG_VOL    = 3'd4
    } t_reg_idx;

    // configuration seen by the front
    typedef struct packed {
        logic [SECT_W-1:0] first;
        logic [SECT_W-1:0] length;
        logic              loop_en;
        logic [CHAN_W-1:0] chan;
        logic [VOL_W-1:0]  vol;
    } t_cfg;

    // actions of one item plus the status after it
    typedef struct packed {
        logic [SLOT_W-1:0]            cnt;
        t_action [SLOTS-1:0]          act;
        logic [SLOTS-1:0][VOL_W-1:0]  vol;
        logic [SECT_W-1:0]            target;
        logic [CHAN_W-1:0]            chan;
        logic                         playing;
    } t_res_set;

    // queue entry: actions plus the sectors that give the elapsed count
    typedef struct packed {
        t_res_set          res;
        logic [SECT_W-1:0] cur;
        logic [SECT_W-1:0] base;
    } t_entry;

endpackage

`default_nettype wire

### design/csps_stream_if.sv
// command and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface csps_cmd_if import csps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic              shell_open;
    logic              drive_seeking;
    logic              drive_standby;
    logic [7:0]        pos_minute_bcd;
    logic [7:0]        pos_second_bcd;
    logic [7:0]        pos_frame_bcd;

    modport source (
        output valid, command, shell_open, drive_seeking, drive_standby,
               pos_minute_bcd, pos_second_bcd, pos_frame_bcd,
        input  ready
    );
    modport sink (
        input  valid, command, shell_open, drive_seeking, drive_standby,
               pos_minute_bcd, pos_second_bcd, pos_frame_bcd,
        output ready
    );
endinterface

interface csps_res_if import csps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        drive_action;
    logic [SECT_W-1:0] target_sector;
    logic [VOL_W-1:0]  mix_volume;
    logic [CHAN_W-1:0] filter_channel;
    logic              is_playing;
    logic [SECT_W-1:0] elapsed_sectors;
    logic [MS_W-1:0]   elapsed_ms;
    logic              last_result;

    modport source (
        output valid, drive_action, target_sector, mix_volume, filter_channel,
               is_playing, elapsed_sectors, elapsed_ms, last_result,
        input  ready
    );
    modport sink (
        input  valid, drive_action, target_sector, mix_volume, filter_channel,
               is_playing, elapsed_sectors, elapsed_ms, last_result,
        output ready
    );
endinterface

`default_nettype wire

### design/cd_stream_playback_supervisor_core.sv
// top level: configuration registers, front, queue and back
`timescale 1ns / 1ps
`default_nettype none

// Supervises streamed CD audio playback. Each command word (tick, play, pause,
// stop) yields one to three result words that carry drive actions plus the
// playing flag and elapsed sectors and ms after the command; last_result marks
// the final word of a command. A command word is taken every cycle while the
// four-entry action queue has room, also while results are stalled. Results
// leave at one word per cycle from the emit register while the receiver is
// ready; that emitter sets the sustained rate. The first result of a command
// passes the input register, the state update into the queue, the elapsed
// subtract, the ms multiply and the emit register.
// Configuration goes through an APB port at byte addresses 0, 4, 8, 12, 16:
// start sector, length, loop enable, channel filter, play volume.

module cd_stream_playback_supervisor_core import csps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csps_cmd_if.sink    i_cmd,
    csps_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SECT_W-1:0] r_first;
    logic [SECT_W-1:0] r_length;
    logic              r_loop_en;
    logic [CHAN_W-1:0] r_chan;
    logic [VOL_W-1:0]  r_play_vol;

    logic              cfg_wr;
    t_reg_idx          reg_idx;
    t_cfg              cfg;
    logic              push;
    logic              full;
    logic              q_valid;
    logic              pop;
    t_entry            push_entry;
    t_entry            head_entry;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_length   <= SECT_W'(1);
            r_loop_en  <= 1'b0;
            r_chan     <= '0;
            r_play_vol <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_START:  r_first    <= pwdata[SECT_W-1:0];
                REG_LENGTH: r_length   <= pwdata[SECT_W-1:0];
                REG_LOOP:   r_loop_en  <= pwdata[0];
                REG_CHAN:   r_chan     <= pwdata[CHAN_W-1:0];
                REG_VOL:    r_play_vol <= pwdata[VOL_W-1:0];
                default:    r_first    <= r_first;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_START:  prdata = 32'(r_first);
            REG_LENGTH: prdata = 32'(r_length);
            REG_LOOP:   prdata = 32'(r_loop_en);
            REG_CHAN:   prdata = 32'(r_chan);
            REG_VOL:    prdata = 32'(r_play_vol);
            default:    prdata = '0;
        endcase
    end

    assign cfg.first   = r_first;
    assign cfg.length  = r_length;
    assign cfg.loop_en = r_loop_en;
    assign cfg.chan    = r_chan;
    assign cfg.vol     = r_play_vol;

    csps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_cfg   (cfg),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    csps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (head_entry)
    );

    csps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### design/csps_front.sv
// front: takes command words, tracks playback state, builds action entries
`timescale 1ns / 1ps
`default_nettype none

module csps_front import csps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    csps_cmd_if.sink i_cmd,
    input  t_cfg   i_cfg,
    input  logic   i_full,
    output logic   o_push,
    output t_entry o_entry
);

    // packed bcd byte to binary, non-bcd digits wrap mod 256
    function automatic logic [7:0] f_bcd(input logic [7:0] x);
        return x - (8'(x[7:4]) * 8'd6);
    endfunction

    // append one action to the result set
    function automatic t_res_set f_emit(input t_res_set s, input t_action a,
                                        input logic [VOL_W-1:0] v);
        t_res_set r;
        r = s;
        if (s.cnt != SLOT_W'(SLOTS)) begin
            r.act[s.cnt] = a;
            r.vol[s.cnt] = v;
            r.cnt        = s.cnt + SLOT_W'(1);
        end
        return r;
    endfunction

    // input stage
    logic              r_a_valid;
    t_cmd              r_a_cmd;
    logic              r_a_shell;
    logic              r_a_seeking;
    logic              r_a_standby;
    logic [SECT_W-1:0] r_a_pos;

    logic              in_fire;
    logic              b_fire;
    logic [POS_W-1:0]  pos_raw;
    logic [SECT_W-1:0] pos_sat;

    // playback state
    logic                r_active, n_active;
    logic                r_playing, n_playing;
    logic                r_seek, n_seek;
    logic                r_loop, n_loop;
    logic                r_wait, n_wait;
    logic [RESYNC_W-1:0] r_resync, n_resync;
    logic [SECT_W-1:0]   r_cur, n_cur;
    logic [SECT_W-1:0]   r_base, n_base;
    logic [END_W-1:0]    r_end, n_end;
    logic [VOL_W-1:0]    r_vol, n_vol;
    t_res_set            n_res;

    assign b_fire      = r_a_valid && !i_full;
    assign i_cmd.ready = !r_a_valid || !i_full;
    assign in_fire     = i_cmd.valid && i_cmd.ready;

    // msf position to absolute sector, saturated
    assign pos_raw = POS_W'(f_bcd(i_cmd.pos_minute_bcd)) * MIN_SECTORS
                   + POS_W'(f_bcd(i_cmd.pos_second_bcd)) * SEC_SECTORS
                   + POS_W'(f_bcd(i_cmd.pos_frame_bcd));
    assign pos_sat = (pos_raw > POS_W'(SECT_MAX)) ? SECT_MAX : pos_raw[SECT_W-1:0];

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (b_fire) begin
            r_a_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_cmd     <= t_cmd'(i_cmd.command);
            r_a_shell   <= i_cmd.shell_open;
            r_a_seeking <= i_cmd.drive_seeking;
            r_a_standby <= i_cmd.drive_standby;
            r_a_pos     <= pos_sat;
        end
    end

    // command decode and state update
    always_comb begin
        logic              go;
        logic              play_emitted;
        logic [SECT_W-1:0] len;
        t_res_set          res;
        n_active     = r_active;
        n_playing    = r_playing;
        n_seek       = r_seek;
        n_loop       = r_loop;
        n_wait       = r_wait;
        n_resync     = r_resync;
        n_cur        = r_cur;
        n_base       = r_base;
        n_end        = r_end;
        n_vol        = r_vol;
        res          = '0;
        go           = 1'b0;
        play_emitted = 1'b0;
        len          = (i_cfg.length == '0) ? SECT_W'(1) : i_cfg.length;
        case (r_a_cmd)
            CMD_TICK: begin
                if (r_playing) begin
                    go = 1'b1;
                    // standby wait or resync countdown
                    if (r_wait) begin
                        if (!r_a_standby) begin
                            go = 1'b0;
                        end else begin
                            n_wait   = 1'b0;
                            res      = f_emit(res, ACT_REINIT, n_vol);
                            res      = f_emit(res, ACT_FILTVOL, n_vol);
                            res.chan = i_cfg.chan;
                        end
                    end else if (r_resync != '0) begin
                        n_resync = r_resync - RESYNC_W'(1);
                        if (n_resync != '0 || r_a_shell) begin
                            go = 1'b0;
                        end else if (!r_a_standby) begin
                            n_wait = 1'b1;
                            go     = 1'b0;
                        end else begin
                            res      = f_emit(res, ACT_REINIT, n_vol);
                            res      = f_emit(res, ACT_FILTVOL, n_vol);
                            res.chan = i_cfg.chan;
                        end
                    end
                    if (go) begin
                        if (r_a_shell) begin
                            // lid open: bump once, mark seeking, arm resync
                            if (!r_seek) begin
                                if (r_cur != SECT_MAX) begin
                                    n_cur = r_cur + SECT_W'(1);
                                end
                                n_seek = 1'b1;
                            end
                            n_resync = RESYNC_TICKS;
                        end else if (!(r_seek && r_a_seeking)) begin
                            // seek done: play at the held position
                            if (r_seek) begin
                                n_seek       = 1'b0;
                                res          = f_emit(res, ACT_PLAY, n_vol);
                                res.target   = r_cur;
                                play_emitted = 1'b1;
                            end
                            if (r_a_pos > r_cur) begin
                                n_cur = r_a_pos;
                            end
                            // end of stream: loop or stop
                            if ({1'b0, n_cur} >= r_end) begin
                                if (play_emitted) begin
                                    res.cnt = res.cnt - SLOT_W'(1);
                                end
                                if (r_loop) begin
                                    n_cur      = r_base;
                                    n_seek     = 1'b1;
                                    res        = f_emit(res, ACT_SEEK, n_vol);
                                    res.target = r_base;
                                end else begin
                                    n_active  = 1'b0;
                                    n_playing = 1'b0;
                                    n_seek    = 1'b0;
                                    n_loop    = 1'b0;
                                    n_wait    = 1'b0;
                                    n_resync  = '0;
                                    n_vol     = '0;
                                    res       = f_emit(res, ACT_PAUSE, n_vol);
                                end
                            end
                        end
                    end
                end
            end
            CMD_PLAY: begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_vol    = '0;
                    res      = f_emit(res, ACT_REINIT, n_vol);
                end
                n_base     = i_cfg.first;
                n_cur      = i_cfg.first;
                n_end      = {1'b0, i_cfg.first} + {1'b0, len} - END_W'(1);
                n_playing  = 1'b1;
                n_seek     = 1'b1;
                n_loop     = i_cfg.loop_en;
                n_wait     = 1'b0;
                n_resync   = '0;
                res        = f_emit(res, ACT_SEEK, n_vol);
                res.target = i_cfg.first;
                n_vol      = i_cfg.vol;
                res        = f_emit(res, ACT_FILTVOL, n_vol);
                res.chan   = i_cfg.chan;
            end
            CMD_PAUSE: begin
                if (r_playing) begin
                    n_playing = 1'b0;
                    res       = f_emit(res, ACT_PAUSE, n_vol);
                end
            end
            CMD_STOP: begin
                if (r_active) begin
                    n_active  = 1'b0;
                    n_playing = 1'b0;
                    n_seek    = 1'b0;
                    n_loop    = 1'b0;
                    n_wait    = 1'b0;
                    n_resync  = '0;
                    n_vol     = '0;
                    res       = f_emit(res, ACT_PAUSE, n_vol);
                end
            end
            default: begin
            end
        endcase
        if (res.cnt == '0) begin
            res = f_emit(res, ACT_NONE, n_vol);
        end
        res.playing = n_playing;
        n_res       = res;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_playing <= 1'b0;
            r_seek    <= 1'b0;
            r_loop    <= 1'b0;
            r_wait    <= 1'b0;
            r_resync  <= '0;
            r_cur     <= '0;
            r_base    <= '0;
            r_end     <= '0;
            r_vol     <= '0;
        end else if (b_fire) begin
            r_active  <= n_active;
            r_playing <= n_playing;
            r_seek    <= n_seek;
            r_loop    <= n_loop;
            r_wait    <= n_wait;
            r_resync  <= n_resync;
            r_cur     <= n_cur;
            r_base    <= n_base;
            r_end     <= n_end;
            r_vol     <= n_vol;
        end
    end

    // entry to the queue
    assign o_push       = b_fire;
    assign o_entry.res  = n_res;
    assign o_entry.cur  = n_cur;
    assign o_entry.base = n_base;

    a_play_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_active)
        else $error("playing without an active stream");

    a_resync_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resync <= RESYNC_TICKS)
        else $error("resync countdown beyond its load value");

    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_entry.res.cnt != '0)
        else $error("entry pushed without any action");

    a_wait_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_wait) |-> r_playing)
        else $error("standby wait armed while not playing");

endmodule

`default_nettype wire

### design/csps_fifo.sv
// short entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module csps_fifo import csps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_entry
);

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

### design/csps_back.sv
// back: elapsed time math and one result word per cycle while the receiver is ready
`timescale 1ns / 1ps
`default_nettype none

module csps_back import csps_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    csps_res_if.source o_res
);

    // elapsed stage
    logic              r_p1_valid;
    t_res_set          r_p1_res;
    logic [SECT_W-1:0] r_p1_el;

    // milliseconds stage
    logic              r_p2_valid;
    t_res_set          r_p2_res;
    logic [SECT_W-1:0] r_p2_el;
    logic [MS_W-1:0]   r_p2_ms;

    // emit stage
    logic              r_e_valid;
    t_res_set          r_e_res;
    logic [SECT_W-1:0] r_e_el;
    logic [MS_W-1:0]   r_e_ms;
    logic [SLOT_W-1:0] r_idx;

    logic              e_last;
    logic              e_take;
    logic              p2_take;
    logic              p1_take;
    logic [PROD_W-1:0] ms_prod;
    t_action           cur_act;

    // stage advance, each stage refills when it empties or hands on
    assign e_last  = (r_idx == r_e_res.cnt - SLOT_W'(1));
    assign e_take  = !r_e_valid || (o_res.ready && e_last);
    assign p2_take = !r_p2_valid || e_take;
    assign p1_take = !r_p1_valid || p2_take;
    assign o_pop   = i_valid && p1_take;

    // elapsed * 40 / 3 by reciprocal multiply
    assign ms_prod = PROD_W'(r_p1_el) * PROD_W'(MS_MULT);

    // valid bits and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_e_valid  <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (p1_take) begin
                r_p1_valid <= i_valid;
            end
            if (p2_take) begin
                r_p2_valid <= r_p1_valid;
            end
            if (e_take) begin
                r_e_valid <= r_p2_valid;
                r_idx     <= '0;
            end else if (o_res.ready) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (p1_take && i_valid) begin
            r_p1_res <= i_entry.res;
            r_p1_el  <= i_entry.cur - i_entry.base;
        end
        if (p2_take && r_p1_valid) begin
            r_p2_res <= r_p1_res;
            r_p2_el  <= r_p1_el;
            r_p2_ms  <= ms_prod[MS_SHIFT +: MS_W];
        end
        if (e_take && r_p2_valid) begin
            r_e_res <= r_p2_res;
            r_e_el  <= r_p2_el;
            r_e_ms  <= r_p2_ms;
        end
    end

    // result word
    assign cur_act               = r_e_res.act[r_idx];
    assign o_res.valid           = r_e_valid;
    assign o_res.drive_action    = cur_act;
    assign o_res.target_sector   = (cur_act inside {ACT_PLAY, ACT_SEEK}) ?
                                   r_e_res.target : '0;
    assign o_res.mix_volume      = r_e_res.vol[r_idx];
    assign o_res.filter_channel  = (cur_act == ACT_FILTVOL) ? r_e_res.chan : '0;
    assign o_res.is_playing      = r_e_res.playing;
    assign o_res.elapsed_sectors = r_e_el;
    assign o_res.elapsed_ms      = r_e_ms;
    assign o_res.last_result     = e_last;

    a_idx_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> r_idx < r_e_res.cnt)
        else $error("result index past the action count");

    a_ms_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_valid |-> (26'(r_p2_ms) * 26'd3 <= 26'(r_p2_el) * 26'd40)
                    && (26'(r_p2_el) * 26'd40 < 26'(r_p2_ms) * 26'd3 + 26'd3))
        else $error("elapsed ms is not elapsed * 40 / 3");

    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid && !o_res.ready |=> r_idx == $past(r_idx))
        else $error("result index moved while the word was stalled");

endmodule

`default_nettype wire

### dv/csps_result_checker.sv
// result checker for the cd stream playback supervisor: predicts and compares result words
`timescale 1ns / 1ps

module csps_result_checker import csps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csps_cmd_if         i_cmd,
    csps_res_if         i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint MS_PER_SECOND = 1000;

    // one expected result word
    typedef struct {
        t_action           act;
        logic [SECT_W-1:0] target;
        logic [VOL_W-1:0]  vol;
        logic [CHAN_W-1:0] chan;
        logic              playing;
        logic [SECT_W-1:0] elapsed;
        logic [MS_W-1:0]   ms;
        logic              last;
    } t_word;

    t_word expected_words[$];
    int    fail_total = 0;

    // register copies
    logic [SECT_W-1:0] start_cfg;
    logic [SECT_W-1:0] length_cfg;
    logic              loop_cfg;
    logic [CHAN_W-1:0] chan_cfg;
    logic [VOL_W-1:0]  vol_cfg;

    // playback state
    logic                active;
    logic                playing;
    logic                seek_pending;
    logic                loop_latched;
    logic                wait_standby;
    logic [RESYNC_W-1:0] resync_count;
    logic [SECT_W-1:0]   current_sector;
    logic [SECT_W-1:0]   begin_sector;
    logic [END_W-1:0]    end_sector;
    logic [VOL_W-1:0]    volume;

    // drive actions of the word being predicted
    t_action           item_act[SLOTS];
    logic [SECT_W-1:0] item_tgt[SLOTS];
    logic [VOL_W-1:0]  item_vol[SLOTS];
    logic [CHAN_W-1:0] item_chan[SLOTS];
    int                item_cnt;

    assign o_fail_count = fail_total;

    function automatic void push_action(t_action a, logic [SECT_W-1:0] tgt,
                                        logic [CHAN_W-1:0] ch);
        if (item_cnt < SLOTS) begin
            item_act[item_cnt]  = a;
            item_tgt[item_cnt]  = tgt;
            item_vol[item_cnt]  = volume;
            item_chan[item_cnt] = ch;
            item_cnt++;
        end
    endfunction

    function automatic void halt_stream();
        active       = 1'b0;
        playing      = 1'b0;
        seek_pending = 1'b0;
        loop_latched = 1'b0;
        wait_standby = 1'b0;
        resync_count = '0;
        volume       = '0;
    endfunction

    // packed bcd byte, non-bcd digits wrap as value - 6 * high nibble
    function automatic int bcd_value(logic [7:0] x);
        logic [7:0] v;
        v = x - 8'(6 * x[7:4]);
        return int'(v);
    endfunction

    function automatic void tick_effect(logic shell, logic seeking, logic standby,
                                        logic [7:0] mm, logic [7:0] ss, logic [7:0] ff);
        int play_at;
        int pos;
        play_at = -1;
        if (!playing)
            return;
        // resync: standby wait or countdown
        if (wait_standby) begin
            if (!standby)
                return;
            wait_standby = 1'b0;
            push_action(ACT_REINIT, '0, '0);
            push_action(ACT_FILTVOL, '0, chan_cfg);
        end else if (resync_count != 0) begin
            resync_count = resync_count - 1'b1;
            if (resync_count != 0 || shell)
                return;
            if (!standby) begin
                wait_standby = 1'b1;
                return;
            end
            push_action(ACT_REINIT, '0, '0);
            push_action(ACT_FILTVOL, '0, chan_cfg);
        end
        // open shell bumps once and arms the countdown
        if (shell) begin
            if (!seek_pending) begin
                if (current_sector != SECT_MAX)
                    current_sector = current_sector + 1'b1;
                seek_pending = 1'b1;
            end
            resync_count = RESYNC_TICKS;
            return;
        end
        if (seek_pending) begin
            if (seeking)
                return;
            seek_pending = 1'b0;
            play_at = item_cnt;
            push_action(ACT_PLAY, current_sector, '0);
        end
        // position only moves the sector forward
        pos = bcd_value(mm) * int'(MIN_SECTORS) + bcd_value(ss) * int'(SEC_SECTORS)
            + bcd_value(ff);
        if (pos > int'(SECT_MAX))
            pos = int'(SECT_MAX);
        if (pos > int'(current_sector))
            current_sector = SECT_W'(pos);
        // end of stream replaces a play issued on this tick
        if (END_W'(current_sector) >= end_sector) begin
            if (play_at >= 0)
                item_cnt = play_at;
            if (loop_latched) begin
                current_sector = begin_sector;
                seek_pending = 1'b1;
                push_action(ACT_SEEK, begin_sector, '0);
            end else begin
                halt_stream();
                push_action(ACT_PAUSE, '0, '0);
            end
        end
    endfunction

    function automatic void predict_command(t_cmd code, logic shell, logic seeking,
                                            logic standby, logic [7:0] mm,
                                            logic [7:0] ss, logic [7:0] ff);
        logic [SECT_W-1:0] len;
        logic [SECT_W-1:0] elapsed;
        t_word             w;
        item_cnt = 0;
        case (code)
            CMD_TICK: tick_effect(shell, seeking, standby, mm, ss, ff);
            CMD_PLAY: begin
                if (!active) begin
                    active = 1'b1;
                    volume = '0;
                    push_action(ACT_REINIT, '0, '0);
                end
                len = (length_cfg == '0) ? SECT_W'(1) : length_cfg;
                begin_sector   = start_cfg;
                current_sector = start_cfg;
                end_sector     = END_W'(start_cfg) + END_W'(len) - 1'b1;
                playing        = 1'b1;
                seek_pending   = 1'b1;
                loop_latched   = loop_cfg;
                wait_standby   = 1'b0;
                resync_count   = '0;
                push_action(ACT_SEEK, start_cfg, '0);
                volume = vol_cfg;
                push_action(ACT_FILTVOL, '0, chan_cfg);
            end
            CMD_PAUSE: begin
                if (playing) begin
                    playing = 1'b0;
                    push_action(ACT_PAUSE, '0, '0);
                end
            end
            default: begin
                if (active) begin
                    halt_stream();
                    push_action(ACT_PAUSE, '0, '0);
                end
            end
        endcase
        if (item_cnt == 0)
            push_action(ACT_NONE, '0, '0);

        // status fields are the same in every word of the command
        elapsed = current_sector - begin_sector;
        for (int k = 0; k < item_cnt; k++) begin
            w.act     = item_act[k];
            w.target  = item_tgt[k];
            w.vol     = item_vol[k];
            w.chan    = item_chan[k];
            w.playing = playing;
            w.elapsed = elapsed;
            w.ms      = MS_W'((longint'(elapsed) * MS_PER_SECOND) / longint'(SEC_SECTORS));
            w.last    = (k == item_cnt - 1);
            expected_words.push_back(w);
        end
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // register writes, command prediction and result comparison
    always @(posedge i_clk) begin : track
        t_word want;
        if (!i_rst_n) begin
            start_cfg      = '0;
            length_cfg     = SECT_W'(1);
            loop_cfg       = 1'b0;
            chan_cfg       = '0;
            vol_cfg        = '0;
            halt_stream();
            current_sector = '0;
            begin_sector   = '0;
            end_sector     = '0;
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_START:  start_cfg  = i_pwdata[SECT_W-1:0];
                    REG_LENGTH: length_cfg = i_pwdata[SECT_W-1:0];
                    REG_LOOP:   loop_cfg   = i_pwdata[0];
                    REG_CHAN:   chan_cfg   = i_pwdata[CHAN_W-1:0];
                    REG_VOL:    vol_cfg    = i_pwdata[VOL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready)
                predict_command(t_cmd'(i_cmd.command), i_cmd.shell_open, i_cmd.drive_seeking,
                                i_cmd.drive_standby, i_cmd.pos_minute_bcd,
                                i_cmd.pos_second_bcd, i_cmd.pos_frame_bcd);
            if (i_res.valid && i_res.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: drive_action %0d",
                           i_res.drive_action);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    fail_total += field_mismatch("drive_action", want.act, i_res.drive_action);
                    fail_total += field_mismatch("target_sector", want.target,
                                                 i_res.target_sector);
                    fail_total += field_mismatch("mix_volume", want.vol, i_res.mix_volume);
                    fail_total += field_mismatch("filter_channel", want.chan,
                                                 i_res.filter_channel);
                    fail_total += field_mismatch("is_playing", want.playing, i_res.is_playing);
                    fail_total += field_mismatch("elapsed_sectors", want.elapsed,
                                                 i_res.elapsed_sectors);
                    fail_total += field_mismatch("elapsed_ms", want.ms, i_res.elapsed_ms);
                    fail_total += field_mismatch("last_result", want.last, i_res.last_result);
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

### dv/testbench.sv
// testbench top: clock, reset, command and register stimulus, final verdict
`timescale 1ns / 1ps

module testbench;
    import csps_pkg::*;

    localparam int         RESET_CYCLES  = 9;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         RANDOM_ITEMS  = 260;
    localparam int         IDLE_PCT      = 14;
    localparam int         LAST_MSF      = 449999;
    localparam int         MAX_LENGTH    = 450000;
    localparam logic [2:0] REG_SPARE     = 3'd5;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    logic        send_gaps;
    logic        take_gaps;

    // register values as last programmed, used to shape the positions
    int          cfg_start;
    int          cfg_length;
    logic        cfg_loop;

    csps_cmd_if cmd_ch ();
    csps_res_if res_ch ();

    cd_stream_playback_supervisor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    csps_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("cd_stream_playback_supervisor_core regression: fail");
        $finish;
    end

    // result side stalls
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= !(take_gaps && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic logic [7:0] to_bcd(int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // absolute sector as bcd minute, second, frame
    function automatic logic [23:0] sector_msf(int sector);
        int rem;
        rem = sector % int'(MIN_SECTORS);
        return {to_bcd(sector / int'(MIN_SECTORS)), to_bcd(rem / int'(SEC_SECTORS)),
                to_bcd(rem % int'(SEC_SECTORS))};
    endfunction

    task automatic send_word(t_cmd c, logic shell, logic seeking, logic standby,
                             logic [7:0] mm, logic [7:0] ss, logic [7:0] ff);
        while (send_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.command        <= c;
        cmd_ch.shell_open     <= shell;
        cmd_ch.drive_seeking  <= seeking;
        cmd_ch.drive_standby  <= standby;
        cmd_ch.pos_minute_bcd <= mm;
        cmd_ch.pos_second_bcd <= ss;
        cmd_ch.pos_frame_bcd  <= ff;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // play, pause or stop with random status and position fields
    task automatic send_control(t_cmd c);
        logic [26:0] noise;
        noise = 27'($urandom());
        send_word(c, noise[26], noise[25], noise[24], noise[23:16], noise[15:8], noise[7:0]);
    endtask

    task automatic send_tick(logic shell, logic seeking, logic standby, logic [23:0] msf);
        send_word(CMD_TICK, shell, seeking, standby, msf[23:16], msf[15:8], msf[7:0]);
    endtask

    // hold commands until every expected word is back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // apb setup and access; the bus is released separately
    task automatic apb_access(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_stream(int first, int length, logic loop_en, int chan, int vol);
        apb_access(REG_START, 32'(first));
        apb_access(REG_LENGTH, 32'(length));
        apb_access(REG_LOOP, 32'(loop_en));
        apb_access(REG_CHAN, 32'(chan));
        apb_access(REG_VOL, 32'(vol));
        apb_release();
        cfg_start  = first;
        cfg_length = length;
        cfg_loop   = loop_en;
    endtask

    task automatic directed_items();
        // idle block ignores everything
        send_tick(1'b1, 1'b1, 1'b1, 24'hFFFFFF);
        send_control(CMD_PAUSE);
        send_control(CMD_STOP);

        // zero length: play is replaced by pause on the first tick
        drain_results();
        apb_access(REG_SPARE, 32'h1F);
        program_stream(100, 0, 1'b0, 31, 255);
        send_control(CMD_PLAY);
        send_tick(1'b0, 1'b0, 1'b1, sector_msf(100));
        send_control(CMD_PLAY);
        send_control(CMD_PAUSE);
        send_tick(1'b0, 1'b0, 1'b1, sector_msf(100));
        send_control(CMD_PLAY);
        send_control(CMD_STOP);

        // last start and longest length: position and bump saturate
        drain_results();
        program_stream(LAST_MSF, MAX_LENGTH, 1'b1, 0, 0);
        send_control(CMD_PLAY);
        send_tick(1'b0, 1'b0, 1'b1, 24'hFFFFFF);
        send_tick(1'b1, 1'b0, 1'b1, 24'h000000);
        send_control(CMD_STOP);

        // one-sector loop: play is replaced by seek to start
        drain_results();
        program_stream(0, 1, 1'b1, 16, 128);
        send_control(CMD_PLAY);
        send_tick(1'b0, 1'b1, 1'b1, 24'h000000);
        send_tick(1'b0, 1'b0, 1'b1, 24'h000000);
        send_control(CMD_STOP);
    endtask

    // one stream: play, then mostly well-formed ticks with drive events
    task automatic run_session(int ticks, int cmd_pct, ref int sent);
        int   stream_pos;
        int   stream_end;
        int   shell_left;
        int   settle_left;
        int   low_left;
        int   r;
        logic stopped;
        logic shell;
        logic seeking;
        logic standby;
        logic [23:0] msf;
        stream_pos  = cfg_start;
        stream_end  = cfg_start + ((cfg_length == 0) ? 1 : cfg_length) - 1;
        shell_left  = 0;
        settle_left = 0;
        low_left    = 0;
        stopped     = 1'b0;
        send_control(CMD_PLAY);
        sent++;
        for (int i = 0; i < ticks && sent < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (stopped && r < 30) begin
                send_control(CMD_PLAY);
                stream_pos = cfg_start;
                stopped = 1'b0;
                sent++;
            end else if (r < cmd_pct) begin
                case (r % 3)
                    0: send_control(CMD_PAUSE);
                    1: send_control(CMD_STOP);
                    default: send_control(CMD_PLAY);
                endcase
                stopped = (r % 3 != 2);
                stream_pos = stopped ? stream_pos : cfg_start;
                sent++;
            end else begin
                // lid events followed by a short seek
                if (shell_left == 0 && $urandom_range(0, 99) < 5)
                    shell_left = $urandom_range(1, 3);
                if (shell_left != 0) begin
                    shell = 1'b1;
                    seeking = 1'($urandom_range(0, 1));
                    shell_left--;
                    if (shell_left == 0)
                        settle_left = $urandom_range(0, 3);
                end else begin
                    shell = 1'b0;
                    seeking = (settle_left != 0) || ($urandom_range(0, 99) < 3);
                    if (settle_left != 0)
                        settle_left--;
                end
                // spindle drops out in short runs
                if (low_left == 0 && $urandom_range(0, 99) < 6)
                    low_left = $urandom_range(1, 6);
                standby = (low_left == 0);
                if (low_left != 0)
                    low_left--;
                // position walks forward, with occasional garbage bytes
                stream_pos += $urandom_range(0, 3);
                if (stream_pos > LAST_MSF)
                    stream_pos = LAST_MSF;
                msf = ($urandom_range(0, 99) < 4) ? 24'($urandom()) : sector_msf(stream_pos);
                send_tick(shell, seeking, standby, msf);
                sent++;
                if (stream_pos > stream_end) begin
                    stream_pos = cfg_start;
                    stopped = !cfg_loop;
                end
            end
        end
    endtask

    task automatic random_sessions();
        int   sent;
        int   session;
        int   first;
        int   length;
        int   chan;
        int   vol;
        int   pick;
        sent = 0;
        session = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            // one stretch with no gaps on either side
            send_gaps = (session != 1);
            take_gaps <= (session != 1);
            pick = $urandom_range(0, 9);
            first = (pick == 0) ? 0 : (pick == 1) ? LAST_MSF : $urandom_range(0, LAST_MSF);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       length = 0;
                1:       length = 1;
                2:       length = MAX_LENGTH;
                3, 4:    length = $urandom_range(151, MAX_LENGTH);
                default: length = $urandom_range(2, 150);
            endcase
            chan = (session == 0) ? 31 : (session == 1) ? 0 : $urandom_range(0, 31);
            vol  = (session == 0) ? 0 : (session == 1) ? 255 : $urandom_range(0, 255);
            program_stream(first, length, 1'($urandom_range(0, 1)), chan, vol);
            run_session($urandom_range(50, 100), (session % 2 == 0) ? 0 : 7, sent);
            session++;
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = CMD_TICK;
        cmd_ch.shell_open     = 1'b0;
        cmd_ch.drive_seeking  = 1'b0;
        cmd_ch.drive_standby  = 1'b0;
        cmd_ch.pos_minute_bcd = '0;
        cmd_ch.pos_second_bcd = '0;
        cmd_ch.pos_frame_bcd  = '0;
        send_gaps             = 1'b1;
        take_gaps             = 1'b1;
        cfg_start             = 0;
        cfg_length            = 1;
        cfg_loop              = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        random_sessions();

        // wait out the last words, then let the pipeline settle
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("cd_stream_playback_supervisor_core regression: pass");
        end else begin
            $display("cd_stream_playback_supervisor_core regression: fail");
        end
        $finish;
    end

endmodule
